// ----- rtl/atsf_pkg.sv -----
// Shared constants, codes and control types of the affine textured span fill.
package atsf_pkg;

  localparam int unsigned SCREEN_PIXELS_WIDE = 128;
  localparam int unsigned SCREEN_LINES       = 256;

  localparam int unsigned HALF_W     = SCREEN_PIXELS_WIDE / 2;
  localparam int unsigned CNT_W      = $clog2(HALF_W + 1);
  localparam int unsigned TEX_BITS   = 5;
  localparam int unsigned TEX_DEPTH  = 1 << (2 * TEX_BITS);
  localparam int unsigned TEX_AW     = 2 * TEX_BITS;
  localparam int unsigned FRAC_BITS  = 8;
  localparam int unsigned CFG_IDX_W  = 1;

  localparam logic CMD_TEXEL = 1'b0;
  localparam logic CMD_SPAN  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_FB_BASE    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BIG_ENDIAN = 1'b1;

  typedef struct packed {
    logic load;
    logic issue;
    logic tex_we;
  } atsf_cmd_t;

  typedef struct packed {
    logic span_go;
    logic texel_go;
    logic out_free;
    logic final_pair;
  } atsf_sts_t;

endpackage

// ----- rtl/atsf_ctrl.sv -----
// Controller state machine: accepts items and sequences the pixel-pair writes.
module atsf_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  atsf_pkg::atsf_sts_t sts_i,
  output atsf_pkg::atsf_cmd_t cmd_o
);

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && (state_q == ST_IDLE);

  always_comb begin
    cmd_o.load   = accept && sts_i.span_go;
    cmd_o.tex_we = accept && sts_i.texel_go;
    cmd_o.issue  = (state_q == ST_RUN) && sts_i.out_free;
    state_d      = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && sts_i.span_go) state_d = ST_RUN;
      end
      ST_RUN: begin
        if (sts_i.out_free && sts_i.final_pair) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- rtl/atsf_dp.sv -----
// Datapath: configuration, texture memory, coordinate stepping and output registers.
module atsf_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  input  logic [atsf_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [31:0]                       cfg_data_i,
  input  logic                              cmd_i,
  input  logic [9:0]                        texel_index_i,
  input  logic [7:0]                        texel_value_i,
  input  logic [6:0]                        x_start_i,
  input  logic [6:0]                        x_end_i,
  input  logic [7:0]                        row_i,
  input  logic signed [31:0]                tex_u_i,
  input  logic signed [31:0]                tex_v_i,
  input  logic signed [31:0]                step_u_i,
  input  logic signed [31:0]                step_v_i,
  input  atsf_pkg::atsf_cmd_t               cmd_in_i,
  output atsf_pkg::atsf_sts_t               sts_o,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [31:0]                       write_addr_o,
  output logic [15:0]                       write_data_o,
  output logic                              last_o
);

  localparam int unsigned TB = atsf_pkg::TEX_BITS;
  localparam int unsigned FB = atsf_pkg::FRAC_BITS;

  logic [7:0] tex_mem [atsf_pkg::TEX_DEPTH];

  logic [31:0] fb_base_q;
  logic        big_endian_q;

  logic [31:0] u_q, v_q, du_q, dv_q, addr_q;
  logic [atsf_pkg::CNT_W-1:0] cnt_q;

  logic        out_valid_q, last_q;
  logic [31:0] out_addr_q;
  logic [7:0]  rd0_q, rd1_q;

  logic signed [8:0] span;
  logic [7:0]        pairs_raw;
  logic [atsf_pkg::CNT_W-1:0] pairs;
  logic [31:0]       row_off, start_addr, u1, v1;
  logic [atsf_pkg::TEX_AW-1:0] ra0, ra1;

  // Pair count, rounded toward zero, saturated at half the screen width
  assign span      = $signed({2'b00, x_end_i}) - $signed({2'b00, x_start_i}) + 9'sd1;
  assign pairs_raw = span[8:1];
  assign pairs     = (32'(pairs_raw) > atsf_pkg::HALF_W) ? atsf_pkg::CNT_W'(atsf_pkg::HALF_W)
                                                          : atsf_pkg::CNT_W'(pairs_raw);

  assign row_off    = 32'(row_i) * 32'(atsf_pkg::HALF_W);
  assign start_addr = fb_base_q + ((row_off + 32'(x_start_i[6:1])) << 1);

  assign u1  = u_q + du_q;
  assign v1  = v_q + dv_q;
  assign ra0 = {v_q[FB+TB-1:FB], u_q[FB+TB-1:FB]};
  assign ra1 = {v1[FB+TB-1:FB], u1[FB+TB-1:FB]};

  assign sts_o.span_go    = (cmd_i == atsf_pkg::CMD_SPAN) && (span >= 9'sd2);
  assign sts_o.texel_go   = (cmd_i == atsf_pkg::CMD_TEXEL);
  assign sts_o.out_free   = !out_valid_q || !out_stall_i;
  assign sts_o.final_pair = (cnt_q == atsf_pkg::CNT_W'(1));

  assign out_valid_o  = out_valid_q;
  assign write_addr_o = out_addr_q;
  assign last_o       = last_q;
  assign write_data_o = big_endian_q ? {rd0_q, rd1_q} : {rd1_q, rd0_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fb_base_q    <= '0;
      big_endian_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          atsf_pkg::CFG_FB_BASE:    fb_base_q    <= cfg_data_i;
          atsf_pkg::CFG_BIG_ENDIAN: big_endian_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (cmd_in_i.issue) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Coordinate walker and output payload
  always_ff @(posedge clk_i) begin
    if (cmd_in_i.load) begin
      u_q    <= tex_u_i;
      v_q    <= tex_v_i;
      du_q   <= step_u_i;
      dv_q   <= step_v_i;
      addr_q <= start_addr;
      cnt_q  <= pairs;
    end else if (cmd_in_i.issue) begin
      u_q    <= u_q + (du_q << 1);
      v_q    <= v_q + (dv_q << 1);
      addr_q <= addr_q + 32'd2;
      cnt_q  <= cnt_q - atsf_pkg::CNT_W'(1);
    end
    if (cmd_in_i.issue) begin
      out_addr_q <= addr_q;
      last_q     <= sts_o.final_pair;
    end
  end

  // Texture memory: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (cmd_in_i.tex_we) begin
      tex_mem[texel_index_i] <= texel_value_i;
    end
    if (cmd_in_i.issue) begin
      rd0_q <= tex_mem[ra0];
      rd1_q <= tex_mem[ra1];
    end
  end

endmodule

// ----- rtl/affine_textured_span_fill.sv -----
// From the edge that accepts a span to its first write, the walker is loaded and then the texture is read
//   into the output registers; a stalled output can hold the read back.
// Throughput: one pixel-pair write per cycle while the output is not stalled; a span keeps the
//   input stalled until its last pair is issued, and a texel write does not stall the input.
// The rate is set by the coordinate walker and the two texture read ports.
// Reset clears the controller, output valid and both configuration registers; texture is not.
module affine_textured_span_fill (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [atsf_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]                    cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           cmd_i,
  input  logic [9:0]                     texel_index_i,
  input  logic [7:0]                     texel_value_i,
  input  logic [6:0]                     x_start_i,
  input  logic [6:0]                     x_end_i,
  input  logic [7:0]                     row_i,
  input  logic signed [31:0]             tex_u_i,
  input  logic signed [31:0]             tex_v_i,
  input  logic signed [31:0]             step_u_i,
  input  logic signed [31:0]             step_v_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [31:0]                    write_addr_o,
  output logic [15:0]                    write_data_o,
  output logic                           last_o
);

  atsf_pkg::atsf_cmd_t cmd;
  atsf_pkg::atsf_sts_t sts;

  assign cfg_ready_o = 1'b1;

  atsf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  atsf_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .cmd_i         (cmd_i),
    .texel_index_i (texel_index_i),
    .texel_value_i (texel_value_i),
    .x_start_i     (x_start_i),
    .x_end_i       (x_end_i),
    .row_i         (row_i),
    .tex_u_i       (tex_u_i),
    .tex_v_i       (tex_v_i),
    .step_u_i      (step_u_i),
    .step_v_i      (step_v_i),
    .cmd_in_i      (cmd),
    .sts_o         (sts),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .write_addr_o  (write_addr_o),
    .write_data_o  (write_data_o),
    .last_o        (last_o)
  );

endmodule

// ----- rtl/atsf_checker.sv -----
// Port-level checker for the affine textured span fill, bound to the top level.
module atsf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        cmd_i,
  input logic [6:0]  x_start_i,
  input logic [6:0]  x_end_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] write_addr_o,
  input logic [15:0] write_data_o,
  input logic        last_o
);

  // Hold a stalled write transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(write_addr_o)
      && $stable(write_data_o) && $stable(last_o))
    else $error("stalled write transaction changed");

  // Writes of an unfinished span keep the input closed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> in_stall_o)
    else $error("input open while span still running");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && cmd_i && (x_end_i > x_start_i) |=> in_stall_o)
    else $error("nonempty span did not start");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !cmd_i |=> !in_stall_o)
    else $error("texel write blocked the input");

endmodule

bind affine_textured_span_fill atsf_checker u_atsf_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .cmd_i        (cmd_i),
  .x_start_i    (x_start_i),
  .x_end_i      (x_end_i),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .write_addr_o (write_addr_o),
  .write_data_o (write_data_o),
  .last_o       (last_o)
);
